FILE: rtl/core/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types and constants of the infix to postfix converter: token kinds,
// stack geometry, the stack entry and the structs passed between the blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

  // stack geometry and payload width
  localparam int STACK_DEPTH = 16;
  localparam int VALUE_BITS  = 16;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int KIND_W      = 3;

  // port packing, data widths padded to whole bytes
  localparam int IN_DATA_W   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int IN_USER_W   = 1 + KIND_W;
  localparam int OUT_DATA_W  = ((VALUE_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_USER_W  = KIND_W;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_OPERAND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OR      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_AND     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OPEN    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLOSE   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OTHER   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_END     = 3'd6;

  // input commands
  localparam logic CMD_TOKEN = 1'b0;
  localparam logic CMD_END   = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  // one result beat handed to the output stage
  typedef struct packed {
    logic                  valid;
    logic [KIND_W-1:0]     kind;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
    logic                  overflow;
  } emit_t;

  // stack memory port requests
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage : itp_pkg

`default_nettype wire

FILE: rtl/core/infix_to_postfix_converter_top.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Reorders classified expression tokens into postfix order with an operator
// stack held in a synchronous memory.
// ----------------------------------------------------------------------------
// An input beat carrying an operand, an open bracket, an and, or an or/other
// operator with no and on top of the stack leaves the sequencer idle, so the
// next beat is accepted as soon as the output register is free. A beat that
// pops the stack starts a pop run, stalled while the output register is full:
// each pop emits the cached top entry while the stack memory reads the entry
// below it; an end command then emits the end marker from its own state, and
// discarding an open bracket passes through a refill state that reloads the
// cached top from the memory. The stack memory needs no clearing pass: only
// entries below the stack count are ever read. Result beats carry the sticky
// overflow flag and tlast on the last beat caused by an input beat; inputs
// that cause no result give no beat.
`default_nettype none

module infix_to_postfix_converter_top
  import itp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // token_value
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // cmd, token_kind
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // out_value, overflow, zero pad
  output logic [OUT_USER_W-1:0]      out_tuser,  // out_kind
  output logic                       out_tlast   // last
);

  emit_t    emit;
  mem_req_t mem_req;
  entry_t   rd_data;
  logic     out_free;

  // sequencer
  itp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser[0]),
    .in_kind  (in_tuser[KIND_W:1]),
    .in_value (in_tdata[VALUE_BITS-1:0]),
    .out_free (out_free),
    .emit     (emit),
    .mem_req  (mem_req),
    .rd_data  (rd_data)
  );

  // operator stack memory
  itp_stack_mem u_stack_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // result register
  itp_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule : infix_to_postfix_converter_top

`default_nettype wire

FILE: rtl/core/itp_stack_mem.sv
// ----------------------------------------------------------------------------
// itp_stack_mem
// Operator stack storage: one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_stack_mem
  import itp_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output entry_t        rd_data
);

  entry_t mem_r [STACK_DEPTH];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : itp_stack_mem

`default_nettype wire

FILE: rtl/core/itp_seq.sv
// ----------------------------------------------------------------------------
// itp_seq
// Token sequencer: keeps the stack count, a cached copy of the top entry and
// the sticky overflow flag, and walks pop runs through the stack memory.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_seq
  import itp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_cmd,
  input  wire logic [KIND_W-1:0]     in_kind,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic                  out_free,
  output emit_t                      emit,
  output mem_req_t                   mem_req,
  input  wire entry_t                rd_data
);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_POP    = 2'd1;
  localparam logic [1:0] S_END    = 2'd2;
  localparam logic [1:0] S_REFILL = 2'd3;

  // pop run modes
  localparam logic [1:0] MODE_CLOSE = 2'd0;
  localparam logic [1:0] MODE_AND   = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  entry_t           top_r, top_nxt;
  entry_t           pend_r, pend_nxt;

  logic [KIND_W-1:0] kind_n;
  logic              accept;
  logic              top_is_and;
  logic              do_push;
  entry_t            push_entry;
  logic              stop;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2, cnt_m3;

  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // undefined kinds act as other operator
  assign kind_n     = (in_kind > KIND_OTHER) ? KIND_OTHER : in_kind;
  assign top_is_and = (count_r != '0) && (top_r.kind == KIND_AND);
  assign push_entry = '{kind: kind_n, value: in_value};

  assign cnt_m1 = count_r - CNT_W'(1);
  assign cnt_m2 = count_r - CNT_W'(2);
  assign cnt_m3 = count_r - CNT_W'(3);

  // last pop of the run, decided from the entry below the top
  always_comb begin
    priority if (count_r == CNT_W'(1)) begin
      stop = 1'b1;
    end else if (mode_r == MODE_CLOSE) begin
      stop = (rd_data.kind == KIND_OPEN);
    end else if (mode_r == MODE_AND) begin
      stop = (rd_data.kind != KIND_AND);
    end else begin
      stop = 1'b0;
    end
  end

  // next state logic
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    top_nxt       = top_r;
    pend_nxt      = pend_r;
    do_push       = 1'b0;
    mem_req       = '0;
    emit          = '0;
    emit.overflow = ovf_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_END) begin
            if (count_r == '0) begin
              emit.valid = 1'b1;
              emit.kind  = KIND_END;
              emit.value = '0;
              emit.last  = 1'b1;
            end else begin
              mode_nxt      = MODE_END;
              mem_req.re    = (count_r >= CNT_W'(2));
              mem_req.raddr = cnt_m2[IDX_W-1:0];
              state_nxt     = S_POP;
            end
          end else begin
            unique case (kind_n)
              KIND_OPERAND: begin
                emit.valid = 1'b1;
                emit.kind  = kind_n;
                emit.value = in_value;
                emit.last  = 1'b1;
              end
              KIND_CLOSE: begin
                if (count_r != '0) begin
                  mem_req.re    = (count_r >= CNT_W'(2));
                  mem_req.raddr = cnt_m2[IDX_W-1:0];
                  if (top_r.kind == KIND_OPEN) begin
                    // matching open bracket on top: drop it silently
                    count_nxt = cnt_m1;
                    if (count_r >= CNT_W'(2)) begin
                      state_nxt = S_REFILL;
                    end
                  end else begin
                    mode_nxt  = MODE_CLOSE;
                    state_nxt = S_POP;
                  end
                end
              end
              KIND_OPEN, KIND_AND: begin
                do_push = 1'b1;
              end
              default: begin
                // or and other operators first pop the and entries
                if (top_is_and) begin
                  mode_nxt      = MODE_AND;
                  pend_nxt      = push_entry;
                  mem_req.re    = (count_r >= CNT_W'(2));
                  mem_req.raddr = cnt_m2[IDX_W-1:0];
                  state_nxt     = S_POP;
                end else begin
                  do_push = 1'b1;
                end
              end
            endcase
          end
        end
      end

      S_POP: begin
        if (out_free) begin
          emit.valid = 1'b1;
          emit.kind  = top_r.kind;
          emit.value = top_r.value;
          emit.last  = stop && (mode_r != MODE_END);
          count_nxt  = cnt_m1;
          top_nxt    = rd_data;
          if (!stop) begin
            mem_req.re    = (count_r >= CNT_W'(3));
            mem_req.raddr = cnt_m3[IDX_W-1:0];
          end else if (mode_r == MODE_END) begin
            state_nxt = S_END;
          end else if (mode_r == MODE_AND) begin
            // the pending operator takes the freed slot
            mem_req.we    = 1'b1;
            mem_req.waddr = cnt_m1[IDX_W-1:0];
            mem_req.wdata = pend_r;
            top_nxt       = pend_r;
            count_nxt     = count_r;
            state_nxt     = S_IDLE;
          end else if (count_r == CNT_W'(1)) begin
            // unmatched close bracket emptied the stack
            state_nxt = S_IDLE;
          end else begin
            // open bracket below: discard it as well
            count_nxt     = cnt_m2;
            mem_req.re    = (count_r >= CNT_W'(3));
            mem_req.raddr = cnt_m3[IDX_W-1:0];
            state_nxt     = (count_r >= CNT_W'(3)) ? S_REFILL : S_IDLE;
          end
        end
      end

      S_END: begin
        if (out_free) begin
          emit.valid = 1'b1;
          emit.kind  = KIND_END;
          emit.value = '0;
          emit.last  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_REFILL: begin
        top_nxt   = rd_data;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // push, dropped when the stack is full
    if (do_push) begin
      if (count_r == CNT_W'(STACK_DEPTH)) begin
        ovf_nxt = 1'b1;
      end else begin
        mem_req.we    = 1'b1;
        mem_req.waddr = count_r[IDX_W-1:0];
        mem_req.wdata = push_entry;
        top_nxt       = push_entry;
        count_nxt     = count_r + CNT_W'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    top_r  <= top_nxt;
    pend_r <= pend_nxt;
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (count_r != '0))
    else $error("pop run on an empty stack");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> out_free)
    else $error("result beat issued while output stage is full");

  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("stack read and write in the same cycle");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(ovf_r) |-> ovf_r)
    else $error("overflow flag cleared outside reset");

endmodule : itp_seq

`default_nettype wire

FILE: rtl/core/itp_out_stage.sv
// ----------------------------------------------------------------------------
// itp_out_stage
// Output register of the result stream: holds one beat and packs it onto the
// master-side ports.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_out_stage
  import itp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire emit_t                  emit,
  output logic                        free,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_DATA_W-1:0]       out_tdata,
  output logic [OUT_USER_W-1:0]       out_tuser,
  output logic                        out_tlast
);

  logic                  valid_r;
  logic [KIND_W-1:0]     kind_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  last_r;
  logic                  ovf_r;

  assign free = !valid_r || out_tready;

  // beat valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= emit.valid;
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if (free && emit.valid) begin
      kind_r  <= emit.kind;
      value_r <= emit.value;
      last_r  <= emit.last;
      ovf_r   <= emit.overflow;
    end
  end

  // port packing
  assign out_tvalid = valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;
  assign out_tdata  = OUT_DATA_W'({ovf_r, value_r});

endmodule : itp_out_stage

`default_nettype wire

FILE: tb/infix_to_postfix_converter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_tb
// Streams classified expression tokens into the converter and checks every
// postfix beat against a shunting-yard predictor kept in the bench, with
// random idle bursts on both streams, a drain pause and a stack overflow run.
// ----------------------------------------------------------------------------

module infix_to_postfix_converter_top_tb
  import itp_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 48;
  // kinds above other operator, folded into other operator by the block
  localparam logic [KIND_W-1:0] KIND_UNDEF6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNDEF7 = 3'd7;

  typedef struct packed {
    logic                  cmd;
    logic [KIND_W-1:0]     kind;
    logic [VALUE_BITS-1:0] value;
  } token_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
    logic                  overflow;
  } postfix_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // token_value
  logic [IN_USER_W-1:0]  in_tuser = '0;   // cmd, token_kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // out_value, overflow, zero pad
  logic [OUT_USER_W-1:0] out_tuser;       // out_kind
  logic                  out_tlast;

  // pending tokens and expected postfix beats
  token_beat_t   token_q[$];
  postfix_beat_t postfix_q[$];

  // shadow of the operator stack
  logic [KIND_W-1:0]     op_kind[STACK_DEPTH];
  logic [VALUE_BITS-1:0] op_value[STACK_DEPTH];
  int                    op_depth = 0;
  logic                  ovf_sticky = 1'b0;

  int   tokens_sent = 0;
  int   tokens_taken = 0;
  int   fail_count = 0;
  int   noise_budget = 0;
  int   cycle_cnt = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  logic idle_on = 1'b1;
  logic in_taken = 1'b0;

  infix_to_postfix_converter_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // pop the top operator into a result beat
  function automatic postfix_beat_t take_top();
    postfix_beat_t b;
    op_depth = op_depth - 1;
    b.kind     = op_kind[op_depth];
    b.value    = op_value[op_depth];
    b.last     = 1'b0;
    b.overflow = 1'b0;
    return b;
  endfunction

  // one shunting-yard step; appends the beats it causes to postfix_q
  task automatic shunt_token(input logic cmd, input logic [KIND_W-1:0] kind,
                             input logic [VALUE_BITS-1:0] value);
    postfix_beat_t     beats[$];
    postfix_beat_t     b;
    logic [KIND_W-1:0] k;
    k = (kind > KIND_OTHER) ? KIND_OTHER : kind;
    if (cmd == CMD_END) begin
      while (op_depth > 0) beats = {beats, take_top()};
      b.kind  = KIND_END;
      b.value = '0;
      beats = {beats, b};
    end else if (k == KIND_OPERAND) begin
      b.kind  = k;
      b.value = value;
      beats = {beats, b};
    end else if (k == KIND_CLOSE) begin
      // pop down to the matching open bracket, which is dropped
      while (op_depth > 0) begin
        if (op_kind[op_depth-1] == KIND_OPEN) begin
          op_depth = op_depth - 1;
          break;
        end
        beats = {beats, take_top()};
      end
    end else begin
      // precedence 0 operators first retire the and operators on top
      if (k != KIND_OPEN && k != KIND_AND) begin
        while (op_depth > 0 && op_kind[op_depth-1] == KIND_AND)
          beats = {beats, take_top()};
      end
      if (op_depth >= STACK_DEPTH) begin
        ovf_sticky = 1'b1;
      end else begin
        op_kind[op_depth]  = k;
        op_value[op_depth] = value;
        op_depth = op_depth + 1;
      end
    end
    // flag and last marker are settled once the whole token is handled
    for (int i = 0; i < beats.size(); i++) begin
      b = beats[i];
      b.overflow = ovf_sticky;
      b.last     = (i == beats.size() - 1);
      postfix_q = {postfix_q, b};
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  task automatic add_token(input logic cmd, input logic [KIND_W-1:0] kind,
                           input logic [VALUE_BITS-1:0] value);
    token_beat_t t;
    t.cmd   = cmd;
    t.kind  = kind;
    t.value = value;
    token_q = {token_q, t};
    tokens_sent++;
  endtask

  function automatic logic [VALUE_BITS-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] rand_operator();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return KIND_OR;
    if (r < 7) return KIND_AND;
    if (r < 9) return KIND_OTHER;
    return $urandom_range(0, 1) ? KIND_UNDEF7 : KIND_UNDEF6;
  endfunction

  // operand or bracketed subexpression, with the odd stray token
  task automatic add_term(input int level);
    if (noise_budget > 0 && $urandom_range(0, 11) == 0) begin
      noise_budget--;
      add_token(CMD_TOKEN, KIND_W'($urandom_range(0, 7)), rand_value());
    end
    if (level < 2 && $urandom_range(0, 3) == 0) begin
      add_token(CMD_TOKEN, KIND_OPEN, rand_value());
      add_expr(level + 1);
      // now and then the close bracket goes missing
      if ($urandom_range(0, 9) != 0)
        add_token(CMD_TOKEN, KIND_CLOSE, rand_value());
    end else begin
      add_token(CMD_TOKEN, KIND_OPERAND, rand_value());
    end
  endtask

  task automatic add_expr(input int level);
    int n_ops;
    n_ops = $urandom_range(0, 3);
    add_term(level);
    repeat (n_ops) begin
      add_token(CMD_TOKEN, rand_operator(), rand_value());
      add_term(level);
    end
  endtask

  // whole expression closed by an end command with junk kind and value
  task automatic add_sentence();
    noise_budget = 2;
    add_expr(0);
    add_token(CMD_END, KIND_W'($urandom_range(0, 7)), rand_value());
  endtask

  task automatic wait_drained();
    while (tokens_taken != tokens_sent || postfix_q.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: input stream
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    token_beat_t t;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // beat still waiting for ready
    end else if (in_gap > 0) begin
      in_gap    <= in_gap - 1;
      in_tvalid <= 1'b0;
    end else if (token_q.size() == 0) begin
      in_tvalid <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      in_gap    <= $urandom_range(0, 12);
      in_tvalid <= 1'b0;
    end else begin
      t = token_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata  <= IN_DATA_W'(t.value);
      in_tuser  <= {t.kind, t.cmd};
    end
  end

  // result stream back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!idle_on) begin
      out_tready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap    <= out_gap - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 6) == 0) begin
      out_gap    <= $urandom_range(0, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares result beats, feeds accepted tokens to the predictor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    postfix_beat_t want;
    postfix_beat_t got;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        got.kind     = out_tuser;
        got.value    = out_tdata[VALUE_BITS-1:0];
        got.overflow = out_tdata[VALUE_BITS];
        got.last     = out_tlast;
        if (postfix_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] unexpected beat: kind %0d value %h last %b ovf %b",
                     $realtime, got.kind, got.value, got.last, got.overflow);
        end else begin
          want = postfix_q.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"[%0t] mismatch: exp kind %0d value %h last %b ovf %b,",
                        " got kind %0d value %h last %b ovf %b"}, $realtime,
                       want.kind, want.value, want.last, want.overflow,
                       got.kind, got.value, got.last, got.overflow);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        shunt_token(in_tuser[0], in_tuser[KIND_W:1], in_tdata[VALUE_BITS-1:0]);
        tokens_taken++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("infix_to_postfix_converter_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // operand extremes, end and close on an empty stack
    add_token(CMD_TOKEN, KIND_OPERAND, '0);
    add_token(CMD_TOKEN, KIND_OPERAND, '1);
    add_token(CMD_END, KIND_UNDEF7, '1);
    add_token(CMD_TOKEN, KIND_CLOSE, 16'h1234);
    // a, two ands, b, or, c: or retires both and operators
    add_token(CMD_TOKEN, KIND_OPERAND, 16'h000a);
    add_token(CMD_TOKEN, KIND_AND, 16'h8001);
    add_token(CMD_TOKEN, KIND_AND, 16'h8002);
    add_token(CMD_TOKEN, KIND_OPERAND, 16'h000b);
    add_token(CMD_TOKEN, KIND_OR, 16'h4001);
    add_token(CMD_TOKEN, KIND_OPERAND, 16'h000c);
    add_token(CMD_END, KIND_OPERAND, '0);
    // undefined kinds stored as other, open bracket pushed without pops
    add_token(CMD_TOKEN, KIND_UNDEF6, 16'h6666);
    add_token(CMD_TOKEN, KIND_UNDEF7, 16'h7777);
    add_token(CMD_TOKEN, KIND_OPEN, 16'h3333);
    add_token(CMD_TOKEN, KIND_AND, 16'h2222);
    add_token(CMD_TOKEN, KIND_OTHER, 16'h5555);
    // bracket closes over the pending operators
    add_token(CMD_TOKEN, KIND_OPERAND, 16'hbeef);
    add_token(CMD_TOKEN, KIND_CLOSE, 16'h4444);
    // unmatched close empties what is left
    add_token(CMD_TOKEN, KIND_OR, 16'h0101);
    add_token(CMD_TOKEN, KIND_CLOSE, '1);
    // unmatched open flushed by the end command
    add_token(CMD_TOKEN, KIND_OPEN, '1);
    add_token(CMD_TOKEN, KIND_OPEN, 16'h0f0f);
    add_token(CMD_END, KIND_CLOSE, 16'hffff);
    // sender holds off until every result is back
    wait_drained();

    // random expressions
    while (tokens_sent < 405) begin
      add_sentence();
      while (token_q.size() > 40) @(negedge clk);
    end
    wait_drained();

    // last stretch: no idling, stack overflow then a few expressions
    idle_on = 1'b0;
    repeat (STACK_DEPTH + 2) begin
      case ($urandom_range(0, 2))
        0:       add_token(CMD_TOKEN, KIND_OR, rand_value());
        1:       add_token(CMD_TOKEN, KIND_OTHER, rand_value());
        default: add_token(CMD_TOKEN, KIND_OPEN, rand_value());
      endcase
    end
    add_token(CMD_TOKEN, KIND_OPERAND, rand_value());
    add_token(CMD_TOKEN, KIND_CLOSE, rand_value());
    add_token(CMD_END, KIND_OPEN, rand_value());
    repeat (3) add_sentence();
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (postfix_q.size() != 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0d expected beats never arrived", postfix_q.size());
    end
    if (fail_count == 0)
      $display("infix_to_postfix_converter_top verification clean");
    else
      $display("infix_to_postfix_converter_top verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/itp_pkg.sv
rtl/core/itp_stack_mem.sv
rtl/core/itp_seq.sv
rtl/core/itp_out_stage.sv
rtl/core/infix_to_postfix_converter_top.sv
tb/infix_to_postfix_converter_top_tb.sv
